FILE: sv/sha1s_pkg.sv
// ----------------------------------------------------------------------------
// sha1s_pkg
// Shared types, constants and helpers for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1s_pkg;

    localparam int WORD_W   = 32;
    localparam int NB_W     = 3;
    localparam int LEN_W    = 64;
    localparam int CHAIN_N  = 5;
    localparam int WIN_N    = 16;
    localparam int ROUNDS   = 80;
    localparam int SLOT_W   = $clog2(WIN_N);
    localparam int ROUND_W  = $clog2(ROUNDS);
    localparam int OCNT_W   = $clog2(CHAIN_N + 1);
    localparam int S_TDATA_W = ((WORD_W + NB_W + 7) / 8) * 8;

    localparam logic [NB_W-1:0] FULL_BYTES = NB_W'(4);

    localparam logic [WORD_W-1:0] H_INIT [0:CHAIN_N-1] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
    };

    localparam logic [WORD_W-1:0] K_0  = 32'h5A82_7999;
    localparam logic [WORD_W-1:0] K_1  = 32'h6ED9_EBA1;
    localparam logic [WORD_W-1:0] K_2  = 32'h8F1B_BCDC;
    localparam logic [WORD_W-1:0] K_3  = 32'hCA62_C1D6;
    localparam logic [7:0]        PAD_BYTE = 8'h80;
    localparam logic [WORD_W-1:0] PAD_MARK = {PAD_BYTE, 24'h0};

    typedef enum logic [2:0] {
        PS_INPUT,
        PS_PAD,
        PS_MARK,
        PS_ZERO,
        PS_LEN_HI,
        PS_LEN_LO
    } t_push_sel;

    typedef struct packed {
        logic             push;
        t_push_sel        sel;
        logic [NB_W-1:0]  nbytes;
        logic             len_add;
        logic             load;
        logic             round;
        logic             add;
        logic             finish;
    } t_cmd;

    typedef struct packed {
        logic slot_full;
        logic slot_at_len;
        logic round_last;
        logic obuf_busy;
    } t_status;

    // final partial word: keep the leading bytes, append the 0x80 marker
    function automatic logic [WORD_W-1:0] pad_word(input logic [WORD_W-1:0] w,
                                                   input logic [NB_W-1:0] nb);
        logic [WORD_W-1:0] r;
        case (nb)
            NB_W'(0): r = PAD_MARK;
            NB_W'(1): r = {w[31:24], PAD_BYTE, 16'h0};
            NB_W'(2): r = {w[31:16], PAD_BYTE, 8'h0};
            NB_W'(3): r = {w[31:8], PAD_BYTE};
            default:  r = w;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/sha1s_ctrl.sv
// ----------------------------------------------------------------------------
// sha1s_ctrl
// Sequencer: input intake, padding, block compression and digest hand-off.
// ----------------------------------------------------------------------------
module sha1s_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [sha1s_pkg::NB_W-1:0]    i_valid_bytes,
    input  logic                          i_last,
    input  sha1s_pkg::t_status            i_status,
    output sha1s_pkg::t_cmd               o_cmd
);

    typedef enum logic [3:0] {
        S_IN,
        S_P80,
        S_ZERO,
        S_LHI,
        S_LLO,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    t_state r_resume, n_resume;

    assign o_s_tready = (r_state == S_IN);

    always_comb begin
        t_state after;
        after    = r_state;
        n_state  = r_state;
        n_resume = r_resume;
        o_cmd    = '0;
        case (r_state)
            S_IN: begin
                if (i_s_tvalid) begin
                    o_cmd.push    = 1'b1;
                    o_cmd.len_add = 1'b1;
                    if (!i_last) begin
                        o_cmd.nbytes = sha1s_pkg::FULL_BYTES;
                        o_cmd.sel    = sha1s_pkg::PS_INPUT;
                        after        = S_IN;
                    end else begin
                        o_cmd.nbytes = (i_valid_bytes > sha1s_pkg::FULL_BYTES) ?
                                       sha1s_pkg::FULL_BYTES : i_valid_bytes;
                        if (o_cmd.nbytes == sha1s_pkg::FULL_BYTES) begin
                            o_cmd.sel = sha1s_pkg::PS_INPUT;
                            after     = S_P80;
                        end else begin
                            o_cmd.sel = sha1s_pkg::PS_PAD;
                            after     = S_ZERO;
                        end
                    end
                end
            end
            S_P80: begin
                o_cmd.push = 1'b1;
                o_cmd.sel  = sha1s_pkg::PS_MARK;
                after      = S_ZERO;
            end
            S_ZERO: begin
                if (i_status.slot_at_len) begin
                    n_state = S_LHI;
                end else begin
                    o_cmd.push = 1'b1;
                    o_cmd.sel  = sha1s_pkg::PS_ZERO;
                    after      = S_ZERO;
                end
            end
            S_LHI: begin
                o_cmd.push = 1'b1;
                o_cmd.sel  = sha1s_pkg::PS_LEN_HI;
                after      = S_LLO;
            end
            S_LLO: begin
                o_cmd.push = 1'b1;
                o_cmd.sel  = sha1s_pkg::PS_LEN_LO;
                after      = S_FIN;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_status.round_last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = r_resume;
            end
            S_FIN: begin
                if (!i_status.obuf_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IN;
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
        // a push into the last slot completes a block
        if (o_cmd.push) begin
            if (i_status.slot_full) begin
                n_state  = S_LOAD;
                n_resume = after;
            end else begin
                n_state = after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IN;
            r_resume <= S_IN;
        end else begin
            r_state  <= n_state;
            r_resume <= n_resume;
        end
    end

endmodule

FILE: sv/sha1s_datapath.sv
// ----------------------------------------------------------------------------
// sha1s_datapath
// Chaining words, round variables, schedule shift window, length counter,
// round unit and the digest output buffer.
// ----------------------------------------------------------------------------
module sha1s_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sha1s_pkg::t_cmd                 i_cmd,
    input  logic [sha1s_pkg::WORD_W-1:0]    i_msg_word,
    output sha1s_pkg::t_status              o_status,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [sha1s_pkg::WORD_W-1:0]    o_m_tdata,
    output logic                            o_m_tlast
);

    localparam int W  = sha1s_pkg::WORD_W;
    localparam int CN = sha1s_pkg::CHAIN_N;
    localparam int WN = sha1s_pkg::WIN_N;

    logic [W-1:0]                     r_chain [0:CN-1];
    logic [W-1:0]                     r_var   [0:CN-1];
    logic [W-1:0]                     r_win   [0:WN-1];
    logic [W-1:0]                     r_obuf  [0:CN-1];
    logic [sha1s_pkg::LEN_W-1:0]      r_bitlen;
    logic [sha1s_pkg::SLOT_W-1:0]     r_slot;
    logic [sha1s_pkg::ROUND_W-1:0]    r_round;
    logic [sha1s_pkg::OCNT_W-1:0]     r_ocnt;

    logic [W-1:0] push_val;
    logic [W-1:0] f_val;
    logic [W-1:0] k_val;
    logic [W-1:0] tmp_val;
    logic [W-1:0] sched_x;
    logic [W-1:0] sched_new;
    logic         m_acc;

    always_comb begin
        case (i_cmd.sel)
            sha1s_pkg::PS_INPUT:  push_val = i_msg_word;
            sha1s_pkg::PS_PAD:    push_val = sha1s_pkg::pad_word(i_msg_word, i_cmd.nbytes);
            sha1s_pkg::PS_MARK:   push_val = sha1s_pkg::PAD_MARK;
            sha1s_pkg::PS_LEN_HI: push_val = r_bitlen[63:32];
            sha1s_pkg::PS_LEN_LO: push_val = r_bitlen[31:0];
            default:              push_val = '0;
        endcase
    end

    always_comb begin
        if (r_round < sha1s_pkg::ROUND_W'(20)) begin
            f_val = (r_var[1] & r_var[2]) | (~r_var[1] & r_var[3]);
            k_val = sha1s_pkg::K_0;
        end else if (r_round < sha1s_pkg::ROUND_W'(40)) begin
            f_val = r_var[1] ^ r_var[2] ^ r_var[3];
            k_val = sha1s_pkg::K_1;
        end else if (r_round < sha1s_pkg::ROUND_W'(60)) begin
            f_val = (r_var[1] & r_var[2]) | (r_var[1] & r_var[3]) | (r_var[2] & r_var[3]);
            k_val = sha1s_pkg::K_2;
        end else begin
            f_val = r_var[1] ^ r_var[2] ^ r_var[3];
            k_val = sha1s_pkg::K_3;
        end
    end

    assign tmp_val   = {r_var[0][26:0], r_var[0][31:27]} + f_val + r_var[4] + k_val + r_win[0];
    assign sched_x   = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
    assign sched_new = {sched_x[30:0], sched_x[31]};

    assign o_status.slot_full   = (r_slot == sha1s_pkg::SLOT_W'(WN - 1));
    assign o_status.slot_at_len = (r_slot == sha1s_pkg::SLOT_W'(WN - 2));
    assign o_status.round_last  = (r_round == sha1s_pkg::ROUND_W'(sha1s_pkg::ROUNDS - 1));
    assign o_status.obuf_busy   = (r_ocnt != '0);

    assign o_m_tvalid = (r_ocnt != '0);
    assign o_m_tdata  = r_obuf[0];
    assign o_m_tlast  = (r_ocnt == sha1s_pkg::OCNT_W'(1));
    assign m_acc      = o_m_tvalid && i_m_tready;

    // schedule window and output buffer: payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            for (int i = 0; i < WN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WN-1] <= push_val;
        end else if (i_cmd.round) begin
            for (int i = 0; i < WN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WN-1] <= sched_new;
        end
        if (i_cmd.finish) begin
            for (int i = 0; i < CN; i++) begin
                r_obuf[i] <= r_chain[i];
            end
        end else if (m_acc) begin
            for (int i = 0; i < CN - 1; i++) begin
                r_obuf[i] <= r_obuf[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CN; i++) begin
                r_chain[i] <= sha1s_pkg::H_INIT[i];
                r_var[i]   <= '0;
            end
            r_bitlen <= '0;
            r_slot   <= '0;
            r_round  <= '0;
            r_ocnt   <= '0;
        end else begin
            if (i_cmd.push) begin
                r_slot <= r_slot + 1'b1;
            end
            if (i_cmd.len_add) begin
                r_bitlen <= r_bitlen + {58'h0, i_cmd.nbytes, 3'b000};
            end
            if (i_cmd.load) begin
                for (int i = 0; i < CN; i++) begin
                    r_var[i] <= r_chain[i];
                end
                r_round <= '0;
            end else if (i_cmd.round) begin
                r_var[0] <= tmp_val;
                r_var[1] <= r_var[0];
                r_var[2] <= {r_var[1][1:0], r_var[1][31:2]};
                r_var[3] <= r_var[2];
                r_var[4] <= r_var[3];
                r_round  <= o_status.round_last ? '0 : r_round + 1'b1;
            end
            if (i_cmd.add) begin
                for (int i = 0; i < CN; i++) begin
                    r_chain[i] <= r_chain[i] + r_var[i];
                end
            end
            if (i_cmd.finish) begin
                for (int i = 0; i < CN; i++) begin
                    r_chain[i] <= sha1s_pkg::H_INIT[i];
                    r_var[i]   <= '0;
                end
                r_bitlen <= '0;
                r_slot   <= '0;
                r_ocnt   <= sha1s_pkg::OCNT_W'(CN);
            end else if (m_acc) begin
                r_ocnt <= r_ocnt - 1'b1;
            end
        end
    end

endmodule

FILE: sv/sha1_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher_core
// SHA-1 over a stream of big-endian 32-bit message words.
// ----------------------------------------------------------------------------
// Message words are taken one per cycle until a 16-word block is full; the
// block is then compressed by one round unit at one round per cycle, which
// holds the input off for the load, the 80 rounds and the chain add. The word
// marked tlast adds the padding pushes (up to 17, plus a step without a push
// that ends the zero fill and an extra compression when fewer than 9 bytes
// remain in the block) and a finish step that moves the digest into the
// output buffer. The five digest words H0..H4 leave from that buffer with
// tlast on H4, while the next message is already accepted; a finished digest
// waits only if the previous one is not yet drained.
module sha1_stream_hasher_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [31:0] msg_word, [34:32] valid_bytes, [39:35] zero
    input  logic [sha1s_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // end_of_msg
    input  logic                               i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [31:0] digest_word
    output logic [sha1s_pkg::WORD_W-1:0]       o_m_axis_tdata,
    // digest_last
    output logic                               o_m_axis_tlast
);

    sha1s_pkg::t_cmd    cmd;
    sha1s_pkg::t_status status;

    sha1s_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_axis_tvalid),
        .o_s_tready    (o_s_axis_tready),
        .i_valid_bytes (i_s_axis_tdata[sha1s_pkg::WORD_W +: sha1s_pkg::NB_W]),
        .i_last        (i_s_axis_tlast),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    sha1s_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_msg_word (i_s_axis_tdata[sha1s_pkg::WORD_W-1:0]),
        .o_status   (status),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast)
    );

endmodule

FILE: sv/sha1s_checker.sv
// ----------------------------------------------------------------------------
// sha1s_checker
// Port-level checks for the SHA-1 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha1s_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    input  logic                               o_s_axis_tready,
    input  logic [sha1s_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,
    input  logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic [sha1s_pkg::WORD_W-1:0]       o_m_axis_tdata,
    input  logic                               o_m_axis_tlast
);

    logic s_acc;
    logic m_acc;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc = o_m_axis_tvalid && i_m_axis_tready;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("digest valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled digest transaction changed");

    a_pad_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && i_s_axis_tlast |=> !o_s_axis_tready)
        else $error("input taken while padding the final block");

    a_gap_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_acc && o_m_axis_tlast |=> !o_m_axis_tvalid)
        else $error("next digest started without reload");

endmodule

bind sha1_stream_hasher_core sha1s_checker u_sha1s_checker (.*);
